/* rtl/bres_pkg.sv */
// ----------------------------------------------------------------------------
// bres_pkg
// Shared types and constants for the Bresenham line pixel generator.
// ----------------------------------------------------------------------------
package bres_pkg;

    localparam int COORD_BITS    = 12;
    localparam int DEC_BITS      = COORD_BITS + 3;
    localparam int COLOR_BITS    = 24;
    localparam int SCREEN_WIDTH  = 1024;
    localparam int SCREEN_HEIGHT = 768;
    localparam int IN_DATA_BITS  = 4 * COORD_BITS;
    localparam int OUT_DATA_BITS = 2 * COORD_BITS + COLOR_BITS;

    localparam logic [COLOR_BITS-1:0] COLOR_RESET = 24'hFFFFFF;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic [COORD_BITS-1:0]        t_delta;
    typedef logic signed [DEC_BITS-1:0]   t_dec;
    typedef logic [COLOR_BITS-1:0]        t_color;

    typedef enum logic {
        REQ_START = 1'b0,
        REQ_STEP  = 1'b1
    } t_req_type;

    typedef struct packed {
        t_req_type req_type;
        t_coord    start_x;
        t_coord    start_y;
        t_coord    end_x;
        t_coord    end_y;
    } t_req;

    typedef struct packed {
        t_coord pixel_x;
        t_coord pixel_y;
        t_color pixel_color;
        logic   visible;
        logic   last;
    } t_pixel;

endpackage

/* rtl/bres_core.sv */
// ----------------------------------------------------------------------------
// bres_core
// Line state and per-item rasterizer logic: loads endpoints on a start
// transaction, emits one pixel and advances the decision term on active steps.
// ----------------------------------------------------------------------------
module bres_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  bres_pkg::t_req    i_req,
    input  bres_pkg::t_color  i_color,
    output logic              o_pix_valid,
    output bres_pkg::t_pixel  o_pix
);

    logic             r_active,      n_active;
    logic             r_major_is_x,  n_major_is_x;
    bres_pkg::t_coord r_cur_x,       n_cur_x;
    bres_pkg::t_coord r_cur_y,       n_cur_y;
    bres_pkg::t_coord r_major_end,   n_major_end;
    logic             r_minor_neg,   n_minor_neg;
    bres_pkg::t_delta r_dmaj,        n_dmaj;
    bres_pkg::t_delta r_dmin,        n_dmin;
    bres_pkg::t_dec   r_dec,         n_dec;

    logic signed [bres_pkg::COORD_BITS:0] w_dx_s, w_dy_s;
    bres_pkg::t_delta w_dx, w_dy, w_dmaj, w_dmin;
    logic             w_major_is_x, w_swap;
    bres_pkg::t_coord w_fmaj, w_fmin, w_lmaj, w_lmin, w_first_maj, w_first_min;
    bres_pkg::t_coord w_maj, w_mnr, w_mnr_next, w_maj_next;
    logic             w_last, w_vis;
    bres_pkg::t_dec   w_dec_init, w_d2min, w_d2maj;

    // endpoint setup
    always_comb begin
        w_dx_s = $signed({i_req.start_x[bres_pkg::COORD_BITS-1], i_req.start_x})
               - $signed({i_req.end_x[bres_pkg::COORD_BITS-1], i_req.end_x});
        w_dy_s = $signed({i_req.start_y[bres_pkg::COORD_BITS-1], i_req.start_y})
               - $signed({i_req.end_y[bres_pkg::COORD_BITS-1], i_req.end_y});
        w_dx = w_dx_s[bres_pkg::COORD_BITS] ? bres_pkg::COORD_BITS'(-w_dx_s)
                                            : w_dx_s[bres_pkg::COORD_BITS-1:0];
        w_dy = w_dy_s[bres_pkg::COORD_BITS] ? bres_pkg::COORD_BITS'(-w_dy_s)
                                            : w_dy_s[bres_pkg::COORD_BITS-1:0];
        w_major_is_x = w_dx > w_dy;
        if (w_major_is_x) begin
            w_dmaj = w_dx;
            w_dmin = w_dy;
            w_fmaj = i_req.start_x;
            w_fmin = i_req.start_y;
            w_lmaj = i_req.end_x;
            w_lmin = i_req.end_y;
        end else begin
            w_dmaj = w_dy;
            w_dmin = w_dx;
            w_fmaj = i_req.start_y;
            w_fmin = i_req.start_x;
            w_lmaj = i_req.end_y;
            w_lmin = i_req.end_x;
        end
        w_swap      = w_fmaj > w_lmaj;
        w_first_maj = w_swap ? w_lmaj : w_fmaj;
        w_first_min = w_swap ? w_lmin : w_fmin;
        w_dec_init  = $signed({2'b00, w_dmin, 1'b0}) - $signed({3'b000, w_dmaj});
    end

    // step datapath
    always_comb begin
        w_maj      = r_major_is_x ? r_cur_x : r_cur_y;
        w_mnr      = r_major_is_x ? r_cur_y : r_cur_x;
        w_last     = w_maj == r_major_end;
        w_vis      = !r_cur_x[bres_pkg::COORD_BITS-1]
                  && (r_cur_x < bres_pkg::t_coord'(bres_pkg::SCREEN_WIDTH))
                  && !r_cur_y[bres_pkg::COORD_BITS-1]
                  && (r_cur_y < bres_pkg::t_coord'(bres_pkg::SCREEN_HEIGHT));
        w_mnr_next = r_minor_neg ? w_mnr - bres_pkg::t_coord'(1)
                                 : w_mnr + bres_pkg::t_coord'(1);
        w_maj_next = w_maj + bres_pkg::t_coord'(1);
        w_d2min    = $signed({2'b00, r_dmin, 1'b0});
        w_d2maj    = $signed({2'b00, r_dmaj, 1'b0});
    end

    always_comb begin
        n_active     = r_active;
        n_major_is_x = r_major_is_x;
        n_cur_x      = r_cur_x;
        n_cur_y      = r_cur_y;
        n_major_end  = r_major_end;
        n_minor_neg  = r_minor_neg;
        n_dmaj       = r_dmaj;
        n_dmin       = r_dmin;
        n_dec        = r_dec;
        o_pix_valid  = 1'b0;
        if (i_en) begin
            unique case (i_req.req_type)
                bres_pkg::REQ_START: begin
                    n_active     = 1'b1;
                    n_major_is_x = w_major_is_x;
                    n_dmaj       = w_dmaj;
                    n_dmin       = w_dmin;
                    n_major_end  = w_swap ? w_fmaj : w_lmaj;
                    n_minor_neg  = !(w_first_min < (w_swap ? w_fmin : w_lmin));
                    n_cur_x      = w_major_is_x ? w_first_maj : w_first_min;
                    n_cur_y      = w_major_is_x ? w_first_min : w_first_maj;
                    n_dec        = w_dec_init;
                end
                bres_pkg::REQ_STEP: begin
                    if (r_active) begin
                        o_pix_valid = 1'b1;
                        if (w_last) begin
                            n_active = 1'b0;
                        end else begin
                            if (r_dec[bres_pkg::DEC_BITS-1]) begin
                                n_dec = r_dec + w_d2min;
                            end else begin
                                n_dec = r_dec + w_d2min - w_d2maj;
                                if (r_major_is_x) begin
                                    n_cur_y = w_mnr_next;
                                end else begin
                                    n_cur_x = w_mnr_next;
                                end
                            end
                            if (r_major_is_x) begin
                                n_cur_x = w_maj_next;
                            end else begin
                                n_cur_y = w_maj_next;
                            end
                        end
                    end
                end
                default: begin
                    n_active = r_active;
                end
            endcase
        end
    end

    always_comb begin
        o_pix.pixel_x     = r_cur_x;
        o_pix.pixel_y     = r_cur_y;
        o_pix.pixel_color = i_color;
        o_pix.visible     = w_vis;
        o_pix.last        = w_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active     <= 1'b0;
            r_major_is_x <= 1'b0;
            r_cur_x      <= '0;
            r_cur_y      <= '0;
            r_major_end  <= '0;
            r_minor_neg  <= 1'b0;
            r_dmaj       <= '0;
            r_dmin       <= '0;
            r_dec        <= '0;
        end else begin
            r_active     <= n_active;
            r_major_is_x <= n_major_is_x;
            r_cur_x      <= n_cur_x;
            r_cur_y      <= n_cur_y;
            r_major_end  <= n_major_end;
            r_minor_neg  <= n_minor_neg;
            r_dmaj       <= n_dmaj;
            r_dmin       <= n_dmin;
            r_dec        <= n_dec;
        end
    end

`ifndef SYNTHESIS
    a_last_ends_line : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && i_req.req_type == bres_pkg::REQ_STEP && r_active && w_last)
        |=> !r_active)
        else $error("line still active after its last pixel");

    a_start_loads : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && i_req.req_type == bres_pkg::REQ_START) |=> r_active)
        else $error("start transaction did not activate a line");

    a_dec_bounds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_dec <= $signed({2'b00, r_dmin, 1'b0}))
                  && (r_dec >= -$signed({2'b00, r_dmaj, 1'b0})))
        else $error("decision term out of range");

    a_minor_le_major : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_dmin <= r_dmaj))
        else $error("minor delta exceeds major delta");
`endif

endmodule

/* rtl/bresenham_line_pixel_generator.sv */
// ----------------------------------------------------------------------------
// bresenham_line_pixel_generator
// Integer Bresenham line rasterizer with stream input and pixel output.
// ----------------------------------------------------------------------------
// A start transaction (tuser 0) loads two endpoints and emits nothing; each
// step transaction (tuser 1) while a line is active emits one pixel, and the
// final endpoint is flagged with tlast, after which steps emit nothing until
// the next start. One transaction is taken per cycle while the output is not
// stalled; each request is registered in r_in and each pixel in r_out.
// ----------------------------------------------------------------------------
module bresenham_line_pixel_generator (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_wr_en,
    input  logic [bres_pkg::COLOR_BITS-1:0]       i_cfg_wr_data,
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    // start_x, start_y, end_x, end_y
    input  logic [bres_pkg::IN_DATA_BITS-1:0]     i_s_tdata,
    // req_type
    input  logic                                  i_s_tuser,
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    // pixel_x, pixel_y, pixel_color
    output logic [bres_pkg::OUT_DATA_BITS-1:0]    o_m_tdata,
    // visible
    output logic                                  o_m_tuser,
    output logic                                  o_m_tlast
);

    localparam int CB = bres_pkg::COORD_BITS;

    logic              r_in_valid;
    bres_pkg::t_req    r_in;
    logic              r_out_valid;
    bres_pkg::t_pixel  r_out;
    bres_pkg::t_color  r_color;
    logic              w_adv;
    logic              w_pix_valid;
    bres_pkg::t_pixel  w_pix;

    assign w_adv      = !r_out_valid || i_m_tready;
    assign o_s_tready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color     <= bres_pkg::COLOR_RESET;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_color <= i_cfg_wr_data;
            end
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (w_adv) begin
                r_out_valid <= r_in_valid && w_pix_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready) begin
            r_in.req_type <= bres_pkg::t_req_type'(i_s_tuser);
            r_in.start_x  <= i_s_tdata[CB-1:0];
            r_in.start_y  <= i_s_tdata[2*CB-1:CB];
            r_in.end_x    <= i_s_tdata[3*CB-1:2*CB];
            r_in.end_y    <= i_s_tdata[4*CB-1:3*CB];
        end
        if (w_adv) begin
            r_out <= w_pix;
        end
    end

    bres_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (r_in_valid && w_adv),
        .i_req       (r_in),
        .i_color     (r_color),
        .o_pix_valid (w_pix_valid),
        .o_pix       (w_pix)
    );

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out.pixel_color, r_out.pixel_y, r_out.pixel_x};
    assign o_m_tuser  = r_out.visible;
    assign o_m_tlast  = r_out.last;

endmodule
